[rtl/pure_pursuit_target_select_unit_assert.svh]
// Assertion macros for the pure pursuit target select unit.
`ifndef PURE_PURSUIT_TARGET_SELECT_UNIT_ASSERT_SVH
`define PURE_PURSUIT_TARGET_SELECT_UNIT_ASSERT_SVH
// Same-cycle implication, checked out of reset.
`define PPTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define PPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/ppts_pkg.sv]
// Shared types, constants and helpers for the pure pursuit target select unit.
package ppts_pkg;

    localparam int MaxWaypoints = 1024;
    localparam int IdxW         = $clog2(MaxWaypoints);
    localparam int CntW         = IdxW + 1;
    localparam int MagW         = 33;
    localparam int SqW          = 2 * MagW;
    localparam int AccW         = SqW + 2;
    localparam int RootW        = 35;
    localparam int LenW         = RootW + 2;
    localparam int LfW          = 31;
    localparam int GainW        = 16;
    localparam int CfgIdxW      = 8;

    localparam logic [LfW-1:0] LfSat = {LfW{1'b1}};

    localparam logic [CfgIdxW-1:0] RegSpeedGain    = 8'd0;
    localparam logic [CfgIdxW-1:0] RegLookaheadMin = 8'd1;
    localparam logic [CfgIdxW-1:0] RegFinishRadius = 8'd2;
    localparam logic [CfgIdxW-1:0] RegWaypointCnt  = 8'd3;

    localparam logic KindLoad  = 1'b0;
    localparam logic KindQuery = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FRS, ST_VEL, ST_VSQ, ST_LF, ST_NRD, ST_NSUM, ST_CRD,
        ST_CLD, ST_WCHK, ST_WRD, ST_WSUM, ST_WSQ, ST_DSUM, ST_OUT
    } state_t;

    // Control of the shared squarer / accumulator
    typedef struct packed {
        logic en;
        logic clr;
    } sq_ctl_t;

    // Magnitude of the difference of two signed 32 bit words
    function automatic logic [MagW-1:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic signed [MagW-1:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        abs_diff = d[MagW-1] ? MagW'(-d) : MagW'(d);
    endfunction

endpackage

[rtl/ppts_sqacc.sv]
// Shared squarer with accumulator: sums the squares of fed magnitudes.
module ppts_sqacc (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ppts_pkg::sq_ctl_t        ctl_i,
    input  logic [ppts_pkg::MagW-1:0] mag_i,
    output logic [ppts_pkg::AccW-1:0] acc_o
);
    import ppts_pkg::*;

    logic [SqW-1:0]  prod_reg;
    logic            pv_reg;
    logic [AccW-1:0] acc_reg;

    // Square the operand, flag the product
    always_ff @(posedge aclk) begin
        prod_reg <= mag_i * mag_i;
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= ctl_i.en;
        end
    end

    // Accumulate registered products
    always_ff @(posedge aclk) begin
        if (ctl_i.clr) begin
            acc_reg <= '0;
        end else if (pv_reg) begin
            acc_reg <= acc_reg + AccW'(prod_reg);
        end
    end

    assign acc_o = acc_reg;
endmodule

[rtl/ppts_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
module ppts_sqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start_i,
    input  logic [ppts_pkg::AccW-1:0]  val_i,
    output logic                      busy_o,
    output logic [ppts_pkg::RootW-1:0] root_o
);
    import ppts_pkg::*;

    localparam int VW   = 2 * RootW;
    localparam int RemW = RootW + 3;

    logic [VW-1:0]    val_reg;
    logic [RemW-1:0]  rem_reg;
    logic [RootW-1:0] root_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;

    assign rem_sh = {rem_reg[RemW-3:0], val_reg[VW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    // Take one result bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start_i) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(RootW - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            val_reg  <= VW'(val_i);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg <= {val_reg[VW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RootW-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RootW-2:0], 1'b0};
            end
        end
    end

    assign busy_o = busy_reg;
    assign root_o = root_reg;
endmodule

[rtl/pure_pursuit_target_select_unit.sv]
// Top level: waypoint table, query sequencer and result register.
//
// Usage: the s_ channel carries transactions; s_tuser selects a waypoint load
// (0) or a pose query (1). A load writes one table slot in its accept cycle
// and returns nothing. A query returns one m_ transaction with the target
// waypoint x, y, index and the done flag.
// The user must write the configuration registers over the cfg_ channel
// (always ready) only while the block is idle; the block does not enforce it.
// A query runs from its accepting edge to m_tvalid through set-up (finish
// radius square, ground speed square root), then the nearest search over the
// waypoints (one table read port and one shared squarer), then the walk,
// a square sum and a square root per walked segment, and then the finish,
// with a distance check against the finish radius when the target is the
// last waypoint. One item at a time: s_tready is low during a query.
// Reset (aresetn low, synchronous) returns the sequencer to idle, drops any
// waiting result and restores the register defaults; the table is not
// cleared. If the receiver stalls, the result is held in the output register;
// loads are still taken, and a later query runs and then holds in its last
// step, with s_tready low, until the register empties.
module pure_pursuit_target_select_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // wp_index, wp_x, wp_y, wp_z, pos_x, pos_y, vel_x, vel_y, zero pad
    input  logic [239:0]                  s_tdata,
    // kind
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // goal x, goal y, target_index, done_res, zero pad
    output logic [79:0]                   m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppts_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [31:0]                   cfg_data
);
    import ppts_pkg::*;
    `include "pure_pursuit_target_select_unit_assert.svh"

    // Input fields
    logic [IdxW-1:0] in_wp_index;
    logic [31:0]     in_wp_x, in_wp_y, in_wp_z, in_pos_x, in_pos_y, in_vel_x, in_vel_y;
    assign in_wp_index = s_tdata[9:0];
    assign in_wp_x     = s_tdata[41:10];
    assign in_wp_y     = s_tdata[73:42];
    assign in_wp_z     = s_tdata[105:74];
    assign in_pos_x    = s_tdata[137:106];
    assign in_pos_y    = s_tdata[169:138];
    assign in_vel_x    = s_tdata[201:170];
    assign in_vel_y    = s_tdata[233:202];

    // Configuration registers
    logic [GainW-1:0] gain_reg;
    logic [LfW-1:0]   lmin_reg, frad_reg;
    logic [CntW-1:0]  wcnt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= '0;
            lmin_reg <= LfW'(65536);
            frad_reg <= LfW'(19661);
            wcnt_reg <= CntW'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                RegSpeedGain:    gain_reg <= cfg_data[GainW-1:0];
                RegLookaheadMin: lmin_reg <= cfg_data[LfW-1:0];
                RegFinishRadius: frad_reg <= cfg_data[LfW-1:0];
                RegWaypointCnt:  wcnt_reg <= cfg_data[CntW-1:0];
                default: ;
            endcase
        end
    end

    // Waypoint table
    logic [31:0]     mem_x [MaxWaypoints];
    logic [31:0]     mem_y [MaxWaypoints];
    logic [31:0]     mem_z [MaxWaypoints];
    logic [IdxW-1:0] rd_addr_reg, rd_addr_next;
    logic [31:0]     rd_x_reg, rd_y_reg, rd_z_reg;
    logic            s_acc;

    assign s_acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser == KindLoad) begin
            mem_x[in_wp_index] <= in_wp_x;
            mem_y[in_wp_index] <= in_wp_y;
            mem_z[in_wp_index] <= in_wp_z;
        end
        rd_x_reg <= mem_x[rd_addr_reg];
        rd_y_reg <= mem_y[rd_addr_reg];
        rd_z_reg <= mem_z[rd_addr_reg];
    end

    // Sequencer state
    state_t          state_reg, state_next;
    logic [2:0]      step_reg, step_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [31:0]     px_reg, py_reg, vx_reg, vy_reg;
    logic [IdxW-1:0] i_reg, i_next, idx_reg, idx_next;
    logic [AccW-1:0] best_reg, best_next;
    logic [SqW-1:0]  frsq_reg, frsq_next;
    logic [GainW+RootW-1:0] lfp_reg, lfp_next;
    logic [LfW-1:0]  lf_reg, lf_next;
    logic [LenW-1:0] len_reg, len_next;
    logic [31:0]     cx_reg, cy_reg, cz_reg, cx_next, cy_next, cz_next;
    logic            done_reg, done_next;
    logic            mv_reg, mv_next;
    logic [79:0]     mdata_reg, mdata_next;

    // Shared units
    sq_ctl_t          sq_ctl;
    logic [MagW-1:0]  sq_mag;
    logic [AccW-1:0]  sq_acc;
    logic             rt_start, rt_busy;
    logic [RootW-1:0] rt_root;
    logic [AccW-1:0]  lf_sum;

    ppts_sqacc u_sqacc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   (sq_ctl),
        .mag_i   (sq_mag),
        .acc_o   (sq_acc)
    );

    ppts_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (rt_start),
        .val_i   (sq_acc),
        .busy_o  (rt_busy),
        .root_o  (rt_root)
    );

    assign lf_sum = AccW'(lfp_reg >> 8) + AccW'(lmin_reg);

    // Pick the squarer operand for the current sum of up to three terms
    always_comb begin
        logic [MagW-1:0] m0, m1, m2;
        m0 = '0;
        m1 = '0;
        m2 = '0;
        unique case (state_reg)
            ST_FRS: m0 = MagW'(frad_reg);
            ST_VEL: begin
                m0 = abs_diff(vx_reg, 32'd0);
                m1 = abs_diff(vy_reg, 32'd0);
            end
            ST_NSUM: begin
                m0 = abs_diff(px_reg, rd_x_reg);
                m1 = abs_diff(py_reg, rd_y_reg);
                m2 = abs_diff(rd_z_reg, 32'd0);
            end
            ST_WSUM: begin
                m0 = abs_diff(rd_x_reg, cx_reg);
                m1 = abs_diff(rd_y_reg, cy_reg);
                m2 = abs_diff(rd_z_reg, cz_reg);
            end
            ST_DSUM: begin
                m0 = abs_diff(px_reg, cx_reg);
                m1 = abs_diff(py_reg, cy_reg);
                m2 = abs_diff(cz_reg, 32'd0);
            end
            default: ;
        endcase
        case (step_reg)
            3'd0:    sq_mag = m0;
            3'd1:    sq_mag = m1;
            default: sq_mag = m2;
        endcase
    end

    // Next state and outputs of the sequencer
    always_comb begin
        logic sum_phase;
        logic [IdxW-1:0] win;
        state_next   = state_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        idx_next     = idx_reg;
        best_next    = best_reg;
        frsq_next    = frsq_reg;
        lfp_next     = lfp_reg;
        lf_next      = lf_reg;
        len_next     = len_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        done_next    = done_reg;
        rd_addr_next = rd_addr_reg;
        rt_start     = 1'b0;
        sq_ctl       = '0;
        mv_next      = mv_reg && !m_tready;
        mdata_next   = mdata_reg;
        win          = idx_reg;
        sum_phase    = (state_reg == ST_FRS || state_reg == ST_VEL ||
                        state_reg == ST_NSUM || state_reg == ST_WSUM ||
                        state_reg == ST_DSUM);

        // Feed three terms, then wait for the last product
        if (sum_phase) begin
            sq_ctl.clr = (step_reg == 3'd0);
            sq_ctl.en  = (step_reg < 3'd3);
            step_next  = step_reg + 3'd1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tuser == KindQuery) begin
                    if (wcnt_reg == '0) begin
                        cnt_next = CntW'(1);
                    end else if (wcnt_reg > CntW'(MaxWaypoints)) begin
                        cnt_next = CntW'(MaxWaypoints);
                    end else begin
                        cnt_next = wcnt_reg;
                    end
                    step_next  = '0;
                    state_next = ST_FRS;
                end
            end
            ST_FRS: begin
                if (step_reg == 3'd4) begin
                    frsq_next  = sq_acc[SqW-1:0];
                    step_next  = '0;
                    state_next = ST_VEL;
                end
            end
            ST_VEL: begin
                if (step_reg == 3'd4) begin
                    rt_start   = 1'b1;
                    state_next = ST_VSQ;
                end
            end
            ST_VSQ: begin
                if (!rt_busy) begin
                    lfp_next   = gain_reg * rt_root;
                    state_next = ST_LF;
                end
            end
            ST_LF: begin
                lf_next      = (lf_sum > AccW'(LfSat)) ? LfSat : lf_sum[LfW-1:0];
                i_next       = '0;
                rd_addr_next = '0;
                state_next   = ST_NRD;
            end
            ST_NRD: begin
                step_next  = '0;
                state_next = ST_NSUM;
            end
            ST_NSUM: begin
                if (step_reg == 3'd4) begin
                    if (i_reg == '0 || sq_acc < best_reg) begin
                        best_next = sq_acc;
                        idx_next  = i_reg;
                        win       = i_reg;
                    end
                    if (CntW'(i_reg) + CntW'(1) < cnt_reg) begin
                        i_next       = i_reg + IdxW'(1);
                        rd_addr_next = i_reg + IdxW'(1);
                        state_next   = ST_NRD;
                    end else begin
                        rd_addr_next = win;
                        state_next   = ST_CRD;
                    end
                end
            end
            ST_CRD: state_next = ST_CLD;
            ST_CLD: begin
                cx_next    = rd_x_reg;
                cy_next    = rd_y_reg;
                cz_next    = rd_z_reg;
                len_next   = '0;
                state_next = ST_WCHK;
            end
            ST_WCHK: begin
                step_next = '0;
                done_next = 1'b0;
                if (LenW'(lf_reg) > len_reg && CntW'(idx_reg) + CntW'(1) < cnt_reg) begin
                    rd_addr_next = idx_reg + IdxW'(1);
                    state_next   = ST_WRD;
                end else if (CntW'(idx_reg) + CntW'(1) == cnt_reg) begin
                    state_next = ST_DSUM;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_WRD: begin
                step_next  = '0;
                state_next = ST_WSUM;
            end
            ST_WSUM: begin
                if (step_reg == 3'd4) begin
                    rt_start   = 1'b1;
                    state_next = ST_WSQ;
                end
            end
            ST_WSQ: begin
                if (!rt_busy) begin
                    len_next   = len_reg + LenW'(rt_root);
                    cx_next    = rd_x_reg;
                    cy_next    = rd_y_reg;
                    cz_next    = rd_z_reg;
                    idx_next   = idx_reg + IdxW'(1);
                    state_next = ST_WCHK;
                end
            end
            ST_DSUM: begin
                if (step_reg == 3'd4) begin
                    done_next  = (sq_acc < AccW'(frsq_reg));
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Load the result once the output register is free
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = {5'd0, done_reg, idx_reg, cy_reg, cx_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mv_reg    <= mv_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser == KindQuery) begin
            px_reg <= in_pos_x;
            py_reg <= in_pos_y;
            vx_reg <= in_vel_x;
            vy_reg <= in_vel_y;
        end
        cnt_reg     <= cnt_next;
        i_reg       <= i_next;
        idx_reg     <= idx_next;
        best_reg    <= best_next;
        frsq_reg    <= frsq_next;
        lfp_reg     <= lfp_next;
        lf_reg      <= lf_next;
        len_reg     <= len_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        done_reg    <= done_next;
        rd_addr_reg <= rd_addr_next;
        mdata_reg   <= mdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

    // Checks
    `PPTS_ASSERT_NOW(a_idx_in_plan, state_reg == ST_OUT, CntW'(idx_reg) < cnt_reg,
        "target index beyond plan")
    `PPTS_ASSERT_NOW(a_sqrt_free, rt_start, !rt_busy, "square root started while busy")
    `PPTS_ASSERT_NEXT(a_result_src, !mv_reg && state_reg != ST_OUT, !m_tvalid,
        "result appeared without a finished query")
endmodule
